// ===== src/signed_int_to_decimal_ascii_top_assert.svh =====
// Assertion macros shared by the decimal text converter modules.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SITDA_ASSERT_NOW(label, ck, rn, cond, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error(msg);
`define SITDA_ASSERT_NEXT(label, ck, rn, cond, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SITDA_ASSERT_NOW(label, ck, rn, cond, expr, msg)
`define SITDA_ASSERT_NEXT(label, ck, rn, cond, expr, msg)
`endif
`endif

// ===== src/sitda_pkg.sv =====
// Shared constants and the converted-record type of the decimal text converter.
// Used by the front, queue, back and top modules.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int DIGITS_W   = MAX_DIGITS * 4;
    localparam int CNT_W      = 4;

    localparam logic [7:0]  ASCII_ZERO  = 8'd48;
    localparam logic [7:0]  ASCII_MINUS = 8'd45;
    localparam logic [7:0]  ASCII_NUL   = 8'd0;
    localparam logic [7:0]  CAP_RESET   = 8'd12;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [DIGITS_W-1:0] digits;
        logic [CNT_W-1:0]    ndig;
        logic                neg;
        logic                fits;
        logic [CNT_W-1:0]    total;
    } sitda_rec_t;

endpackage

// ===== src/sitda_front.sv =====
// Front part: accepts a value, forms its magnitude, peels decimal digits
// with a reciprocal multiply and checks the fit. Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_front
    import sitda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] value,
    input  logic [7:0]         capacity,
    input  logic               q_full,
    output logic               q_push,
    output sitda_rec_t         q_wdata,
    output logic               busy
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIG  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [31:0]         mag_reg, mag_next;
    logic [28:0]         quot_reg, quot_next;
    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic [CNT_W-1:0]    ndig_reg, ndig_next;
    logic                neg_reg, neg_next;

    logic [63:0]    prod;
    logic [31:0]    quot_ext;
    logic [31:0]    diff;
    logic [CNT_W-1:0] total;

    assign prod     = 64'(mag_reg) * 64'(RECIP_TEN);
    assign quot_ext = 32'(quot_reg);
    assign diff     = mag_reg - ((quot_ext << 3) + (quot_ext << 1));
    assign total    = ndig_reg + CNT_W'(neg_reg) + CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        quot_next   = quot_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        neg_next    = neg_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    neg_next   = value[31];
                    mag_next   = value[31] ? (~value + 32'd1) : value;
                    ndig_next  = '0;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                quot_next  = prod[RECIP_SHIFT +: 29];
                state_next = F_DIG;
            end
            F_DIG:
            begin
                digits_next = {diff[3:0], digits_reg[DIGITS_W-1:4]};
                ndig_next   = ndig_reg + CNT_W'(1);
                mag_next    = quot_ext;
                state_next  = (quot_reg == '0) ? F_PUSH : F_MUL;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        quot_reg   <= quot_next;
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        neg_reg    <= neg_next;
    end

    assign busy           = (state_reg != F_IDLE);
    assign q_push         = (state_reg == F_PUSH) && !q_full;
    assign q_wdata.digits = digits_reg;
    assign q_wdata.ndig   = ndig_reg;
    assign q_wdata.neg    = neg_reg;
    assign q_wdata.total  = total;
    assign q_wdata.fits   = ({4'b0, total} <= capacity);

endmodule

// ===== src/sitda_queue.sv =====
// Two-record queue between the converter front and the text emitter back.
// Depends on sitda_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sitda_queue
    import sitda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sitda_rec_t wdata,
    input  logic       pop,
    output sitda_rec_t rdata,
    output logic       full,
    output logic       empty
);

    sitda_rec_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    `SITDA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= 2'd2, "queue count overflow")
    `SITDA_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "push into a full queue")
    `SITDA_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 2'd1, "pop did not drain")

endmodule

// ===== src/sitda_back.sv =====
// Back part: emits the sign, digits and terminator of converted records,
// or an error beat, one per cycle. Depends on sitda_pkg and macro header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sitda_back
    import sitda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sitda_rec_t q_rdata,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       strobe,
    output logic [7:0] character,
    output logic       last,
    output logic [3:0] length
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_ERR  = 5'b00010,
        B_SIGN = 5'b00100,
        B_DIGS = 5'b01000,
        B_TERM = 5'b10000
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    total_reg, total_next;

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    digits_next = q_rdata.digits;
                    cnt_next    = q_rdata.ndig;
                    total_next  = q_rdata.total;
                    if (!q_rdata.fits)
                    begin
                        state_next = B_ERR;
                    end
                    else if (q_rdata.neg)
                    begin
                        state_next = B_SIGN;
                    end
                    else
                    begin
                        state_next = B_DIGS;
                    end
                end
            end
            B_ERR:
            begin
                state_next = B_IDLE;
            end
            B_SIGN:
            begin
                state_next = B_DIGS;
            end
            B_DIGS:
            begin
                digits_next = {digits_reg[DIGITS_W-5:0], 4'd0};
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = B_TERM;
                end
            end
            B_TERM:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        total_reg  <= total_next;
    end

    always_comb
    begin
        character = ASCII_NUL;
        case (state_reg)
            B_SIGN:  character = ASCII_MINUS;
            B_DIGS:  character = ASCII_ZERO + {4'd0, digits_reg[DIGITS_W-1 -: 4]};
            default: character = ASCII_NUL;
        endcase
    end

    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign strobe = (state_reg != B_IDLE);
    assign last   = (state_reg == B_ERR) || (state_reg == B_TERM);
    assign length = (state_reg == B_TERM) ? total_reg : 4'd0;

    `SITDA_ASSERT_NEXT(a_term_ends, clk, rst_n, state_reg == B_TERM, state_reg == B_IDLE, "terminator not followed by idle")
    `SITDA_ASSERT_NOW(a_digit_count, clk, rst_n, state_reg == B_DIGS, cnt_reg != '0, "digit beat with no digit left")
    `SITDA_ASSERT_NOW(a_total_range, clk, rst_n, state_reg == B_TERM, (total_reg >= 4'd2) && (total_reg <= 4'd12), "length out of range")

endmodule

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed 32-bit to decimal text converter.
// Depends on sitda_pkg, sitda_front, sitda_queue and sitda_back.
//
// An item is taken when start is high and busy is low. The front peels each
// decimal digit with a 32 by 32 reciprocal multiply, then the digit subtract,
// and has states of its own to accept the value and to push the record; that
// loop sets the sustained rate. A two-record queue lets the front work on the
// next value while the back emits text at one beat per cycle: an optional
// sign, the digits, then the terminator beat with last and length. A value
// that does not fit the buffer capacity gives a single beat with last set and
// length zero. The receiver cannot stall: every strobe beat must be taken.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               strobe,
    output logic [7:0]         character,
    output logic               last,
    output logic [3:0]         length
);

    logic [7:0] capacity_reg;
    sitda_rec_t q_wdata, q_rdata;
    logic       q_push, q_pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    sitda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .capacity (capacity_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .busy     (busy)
    );

    sitda_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    sitda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .length    (length)
    );

endmodule
